>>> rtl/chbd_pkg.sv
// Shared types, character codes and helper functions for the chunked body decoder.
// Has no dependencies; every other file of the block imports it.
package chbd_pkg;

  localparam int CHBD_LEN_BITS = 32;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X_UC  = 8'h58;
  localparam logic [7:0] CH_X_LC  = 8'h78;

  typedef enum logic [2:0] {
    PH_WS   = 3'd0,
    PH_SIGN = 3'd1,
    PH_NUM  = 3'd2,
    PH_LINE = 3'd3,
    PH_DATA = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    DC_NONE   = 2'd0,
    DC_ZERO   = 2'd1,
    DC_X      = 2'd2,
    DC_DIGITS = 2'd3
  } digit_count_t;

  typedef struct packed {
    logic       valid;
    logic       is_end;
    logic [7:0] data;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // Value of a hex digit; meaningless when is_hex is false.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    if (c <= 8'h39) v = c[3:0];
    else v = 4'(c[3:0] + 4'd9);
    return v;
  endfunction

endpackage

>>> rtl/chbd_step.sv
// Combinational parser step: one body byte against the held parse state.
// Depends on chbd_pkg for the phase codes, character codes and result type.
module chbd_step import chbd_pkg::*; #(
  parameter int LEN_BITS = CHBD_LEN_BITS
) (
  input  phase_t              phase,
  input  logic [LEN_BITS-1:0] size_acc,
  input  logic [LEN_BITS-1:0] bytes_left,
  input  digit_count_t        digit_count,
  input  logic                negative_size,
  input  logic [7:0]          in_byte,
  input  logic                new_body,
  output phase_t              phase_next,
  output logic [LEN_BITS-1:0] size_acc_next,
  output logic [LEN_BITS-1:0] bytes_left_next,
  output digit_count_t        digit_count_next,
  output logic                negative_size_next,
  output result_t             res
);

  localparam logic [LEN_BITS-1:0] LEN_ONE = {{(LEN_BITS-1){1'b0}}, 1'b1};

  phase_t              ph;
  logic [LEN_BITS-1:0] acc;
  logic [LEN_BITS-1:0] left;
  digit_count_t        dc;
  logic                neg;
  logic                hex;
  logic [3:0]          dval;
  logic [LEN_BITS-1:0] dval_ext;
  logic [LEN_BITS-1:0] acc_shift;
  logic                acc_sat;
  logic                is_sign;
  logic                is_x;
  logic                num_bad;
  logic                left_one;

  // A new body restarts from the reset state before this byte is looked at.
  always_comb begin
    if (new_body) begin
      ph   = PH_WS;
      acc  = '0;
      left = '0;
      dc   = DC_NONE;
      neg  = 1'b0;
    end else begin
      ph   = phase;
      acc  = size_acc;
      left = bytes_left;
      dc   = digit_count;
      neg  = negative_size;
    end
  end

  assign hex       = is_hex(in_byte);
  assign dval      = hex_val(in_byte);
  assign dval_ext  = {{(LEN_BITS-4){1'b0}}, dval};
  // Saturate once any of the top four bits would be shifted out.
  assign acc_sat   = |acc[LEN_BITS-1 -: 4];
  assign acc_shift = acc_sat ? '1 : {acc[LEN_BITS-5:0], dval};
  assign is_sign   = (in_byte == CH_PLUS) || (in_byte == CH_MINUS);
  assign is_x      = (in_byte == CH_X_LC) || (in_byte == CH_X_UC);
  assign num_bad   = (dc != DC_DIGITS) || neg || (acc == '0);
  assign left_one  = (left == LEN_ONE);

  // Next state
  always_comb begin
    phase_next         = ph;
    size_acc_next      = acc;
    bytes_left_next    = left;
    digit_count_next   = dc;
    negative_size_next = neg;
    unique case (ph)
      PH_WS: begin
        if (is_space(in_byte)) begin
          phase_next = PH_WS;
        end else if (is_sign) begin
          negative_size_next = (in_byte == CH_MINUS);
          phase_next         = PH_SIGN;
        end else if (hex) begin
          size_acc_next    = dval_ext;
          digit_count_next = (dval == 4'd0) ? DC_ZERO : DC_DIGITS;
          phase_next       = PH_NUM;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_SIGN: begin
        if (hex) begin
          size_acc_next    = dval_ext;
          digit_count_next = (dval == 4'd0) ? DC_ZERO : DC_DIGITS;
          phase_next       = PH_NUM;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_NUM: begin
        if ((dc == DC_ZERO) && is_x) begin
          digit_count_next = DC_X;
        end else if (hex) begin
          size_acc_next    = (dc == DC_DIGITS) ? acc_shift : dval_ext;
          digit_count_next = DC_DIGITS;
        end else if (num_bad) begin
          phase_next = PH_DONE;
        end else begin
          bytes_left_next = acc;
          if (in_byte == CH_LF) phase_next = PH_DATA;
          else if (in_byte == CH_NUL) phase_next = PH_DONE;
          else phase_next = PH_LINE;
        end
      end
      PH_LINE: begin
        if (in_byte == CH_LF) phase_next = PH_DATA;
        else if (in_byte == CH_NUL) phase_next = PH_DONE;
      end
      PH_DATA: begin
        if (left != '0) bytes_left_next = left - LEN_ONE;
        // Last payload byte of the chunk: back to the next size line.
        if ((left == '0) || left_one) begin
          phase_next         = PH_WS;
          size_acc_next      = '0;
          digit_count_next   = DC_NONE;
          negative_size_next = 1'b0;
        end
      end
      default: begin
        phase_next = ph;
      end
    endcase
  end

  // Result
  always_comb begin
    res = '0;
    unique case (ph)
      PH_WS: begin
        res.is_end = !is_space(in_byte) && !is_sign && !hex;
        res.valid  = res.is_end;
      end
      PH_SIGN: begin
        res.is_end = !hex;
        res.valid  = res.is_end;
      end
      PH_NUM: begin
        res.is_end = !((dc == DC_ZERO) && is_x) && !hex &&
                     (num_bad || (in_byte == CH_NUL));
        res.valid  = res.is_end;
      end
      PH_LINE: begin
        res.is_end = (in_byte == CH_NUL);
        res.valid  = res.is_end;
      end
      PH_DATA: begin
        res.valid = 1'b1;
        res.data  = in_byte;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

>>> rtl/http_chunked_body_decoder.sv
// Top level of the HTTP chunked body decoder: input register, parse state, result register.
// Depends on chbd_pkg and chbd_step.
//
// Decodes an HTTP chunked-transfer body at one byte per clock. Raw body bytes enter on the
// s_ side (tuser high marks the first byte of a new body); only chunk payload bytes leave on
// the m_ side, and the end of the body is one item with tlast high and tdata zero. Size lines
// are hex, read as a base-16 strtol would read them, saturating at 2^LEN_BITS-1. Each byte
// is held in the input register and is then parsed into the result register, so a new
// byte is taken every cycle while the output side keeps up; a stalled output holds the
// pipeline through the chained ready. Bytes after the end of a body give nothing until
// the next new-body byte.
module http_chunked_body_decoder import chbd_pkg::*; #(
  parameter int LEN_BITS = CHBD_LEN_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tuser,   // [0] new_body
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast
);

  logic                in_valid;
  logic [7:0]          in_byte;
  logic                in_new;
  logic                advance;

  phase_t              phase;
  phase_t              phase_next;
  logic [LEN_BITS-1:0] size_acc;
  logic [LEN_BITS-1:0] size_acc_next;
  logic [LEN_BITS-1:0] bytes_left;
  logic [LEN_BITS-1:0] bytes_left_next;
  digit_count_t        digit_count;
  digit_count_t        digit_count_next;
  logic                negative_size;
  logic                negative_size_next;
  result_t             res;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_new  <= s_tuser;
    end
  end

  chbd_step #(
    .LEN_BITS(LEN_BITS)
  ) u_step (
    .phase              (phase),
    .size_acc           (size_acc),
    .bytes_left         (bytes_left),
    .digit_count        (digit_count),
    .negative_size      (negative_size),
    .in_byte            (in_byte),
    .new_body           (in_new),
    .phase_next         (phase_next),
    .size_acc_next      (size_acc_next),
    .bytes_left_next    (bytes_left_next),
    .digit_count_next   (digit_count_next),
    .negative_size_next (negative_size_next),
    .res                (res)
  );

  // Parse state advances once per byte leaving the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WS;
      size_acc      <= '0;
      bytes_left    <= '0;
      digit_count   <= DC_NONE;
      negative_size <= 1'b0;
    end else if (advance) begin
      phase         <= phase_next;
      size_acc      <= size_acc_next;
      bytes_left    <= bytes_left_next;
      digit_count   <= digit_count_next;
      negative_size <= negative_size_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      m_tdata <= res.data;
      m_tlast <= res.is_end;
    end
  end

  a_end_no_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == 8'h00)
    else $error("end item carries a data byte");

  a_end_enters_done: assert property (@(posedge clk) disable iff (rst)
    advance && res.valid && res.is_end |=> phase == PH_DONE)
    else $error("end item not followed by the done phase");

  a_data_has_bytes: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> bytes_left != '0)
    else $error("payload phase with no bytes left");

  a_num_has_digit: assert property (@(posedge clk) disable iff (rst)
    phase == PH_NUM |-> digit_count != DC_NONE)
    else $error("number phase without a digit");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    advance && (phase == PH_DONE) && !in_new |=> !m_tvalid)
    else $error("item produced after the end of the body");

endmodule

>>> tb/http_chunked_body_decoder_tb.sv
// Self-checking testbench for http_chunked_body_decoder: random and directed chunked bodies,
// random idling on both stream sides, and an in-bench predictor of the decoded stream.
// Depends on chbd_pkg and the RTL of the block.
module http_chunked_body_decoder_tb;
  import chbd_pkg::*;

  localparam int WATCHDOG_CYCLES = 3000;
  localparam logic [63:0] LEN_MAX = (64'd1 << CHBD_LEN_BITS) - 64'd1;

  typedef struct {
    logic [7:0] data;
    logic       first;
  } body_byte_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] in_byte
  logic       s_tuser = 1'b0;    // [0] new_body
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_byte
  logic       m_tlast;

  http_chunked_body_decoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  body_byte_t raw_q[$];
  decoded_t   decoded_q[$];

  // predictor state
  phase_t       dec_phase = PH_WS;
  logic [63:0]  chunk_len = '0;
  logic [63:0]  payload_left = '0;
  digit_count_t dec_digits = DC_NONE;
  logic         dec_neg = 1'b0;

  int  errors = 0;
  int  idle_cycles = 0;
  int  in_pause = 0;
  int  out_pause = 0;
  bit  calm = 1'b0;
  logic s_fire = 1'b0;
  int  byte_tally = 0;
  int  bodies = 0;
  int  payload_seen = 0;
  int  ends_seen = 0;
  logic mark_first = 1'b0;
  body_byte_t nxt;
  decoded_t   got;

  initial forever #10 clk = ~clk;

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Start a fresh size line: white space skipping, no digits, positive.
  task automatic clear_size_line();
    dec_phase  = PH_WS;
    chunk_len  = '0;
    dec_digits = DC_NONE;
    dec_neg    = 1'b0;
  endtask

  task automatic start_number(input logic [3:0] v);
    chunk_len  = 64'(v);
    dec_digits = (v == 4'd0) ? DC_ZERO : DC_DIGITS;
    dec_phase  = PH_NUM;
  endtask

  task automatic decode_byte(input logic [7:0] c, input logic first);
    logic        hex_ok;
    logic [3:0]  hv;
    logic [63:0] hv_w;
    logic        space;
    logic        finish_body;
    hex_ok = 1'b1;
    hv = '0;
    if (c >= "0" && c <= "9") hv = 4'(c - "0");
    else if (c >= "a" && c <= "f") hv = 4'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") hv = 4'(c - "A" + 8'd10);
    else hex_ok = 1'b0;
    hv_w = 64'(hv);
    space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
            (c == CH_FF) || (c == CH_CR);
    finish_body = 1'b0;
    if (first) begin
      clear_size_line();
      payload_left = '0;
    end
    case (dec_phase)
      PH_WS: begin
        if (space) begin
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          dec_neg   = (c == CH_MINUS);
          dec_phase = PH_SIGN;
        end else if (hex_ok) begin
          start_number(hv);
        end else begin
          finish_body = 1'b1;
        end
      end
      PH_SIGN: begin
        if (hex_ok) start_number(hv);
        else finish_body = 1'b1;
      end
      PH_NUM: begin
        if (dec_digits == DC_ZERO && (c == CH_X_LC || c == CH_X_UC)) begin
          dec_digits = DC_X;
        end else if (hex_ok) begin
          if (dec_digits != DC_DIGITS) chunk_len = hv_w;
          else if (chunk_len > (LEN_MAX - hv_w) / 64'd16) chunk_len = LEN_MAX;
          else chunk_len = chunk_len * 64'd16 + hv_w;
          dec_digits = DC_DIGITS;
        end else if (dec_digits != DC_DIGITS || dec_neg || chunk_len == 64'd0) begin
          finish_body = 1'b1;
        end else begin
          payload_left = chunk_len;
          if (c == CH_LF) dec_phase = PH_DATA;
          else if (c == CH_NUL) finish_body = 1'b1;
          else dec_phase = PH_LINE;
        end
      end
      PH_LINE: begin
        if (c == CH_LF) dec_phase = PH_DATA;
        else if (c == CH_NUL) finish_body = 1'b1;
      end
      PH_DATA: begin
        decoded_q.push_back('{data: c, last: 1'b0});
        if (payload_left > 64'd0) payload_left = payload_left - 64'd1;
        if (payload_left == 64'd0) clear_size_line();
      end
      default: begin
      end
    endcase
    if (finish_body) begin
      dec_phase = PH_DONE;
      decoded_q.push_back('{data: 8'h00, last: 1'b1});
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    raw_q.push_back('{data: b, first: mark_first});
    mark_first = 1'b0;
    byte_tally++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic begin_body();
    mark_first = 1'b1;
    bodies++;
  endtask

  // One random body: mostly well-formed chunks with random content, sometimes noise.
  task automatic add_random_body();
    int          nchunks;
    int          len;
    int          pick;
    int          n;
    string       txt;
    logic [7:0]  b;
    logic [7:0]  ws_set [6];
    ws_set = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    begin_body();
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      // broken body: raw noise
      n = $urandom_range(1, 8);
      repeat (n) push_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (pick < 10) begin
      // size saturates; payload then runs until the next body starts
      n = $urandom_range(9, 12);
      repeat (n) push_byte(($urandom_range(0, 1) != 0) ? "F" : "f");
      push_byte(CH_LF);
      n = $urandom_range(1, 10);
      repeat (n) push_byte(8'($urandom_range(0, 255)));
      return;
    end
    nchunks = $urandom_range(0, 4);
    repeat (nchunks) begin
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 2);
        repeat (n) push_byte(ws_set[$urandom_range(0, 5)]);
      end
      if ($urandom_range(0, 9) == 0) push_byte(CH_PLUS);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      if ($urandom_range(0, 7) == 0) begin
        push_byte("0");
        push_byte(($urandom_range(0, 1) != 0) ? CH_X_UC : CH_X_LC);
      end else if ($urandom_range(0, 7) == 0) begin
        push_byte("0");
      end
      txt = $sformatf("%0h", len);
      for (int i = 0; i < txt.len(); i++) begin
        b = txt[i];
        if (b >= "a" && $urandom_range(0, 1) != 0) b = b - 8'h20;
        push_byte(b);
      end
      if ($urandom_range(0, 5) == 0) begin
        push_byte(";");
        n = $urandom_range(1, 4);
        repeat (n) begin
          b = 8'($urandom_range(1, 255));
          if (b == CH_LF) b = "e";
          push_byte(b);
        end
      end
      if ($urandom_range(0, 4) != 0) push_byte(CH_CR);
      push_byte(CH_LF);
      repeat (len) push_byte(8'($urandom_range(0, 255)));
      push_byte(CH_CR);
      push_byte(CH_LF);
    end
    pick = $urandom_range(0, 9);
    case (pick)
      0: push_str("-3\n");
      1: begin
        push_byte("5");
        push_byte(CH_NUL);
      end
      2: begin
        n = $urandom_range(1, 6);
        repeat (n) push_byte(8'($urandom_range(0, 255)));
      end
      default: push_str("0\r\n");
    endcase
    // trailing bytes after the end are ignored by the block; leave them out of the tally
    n = $urandom_range(0, 3);
    repeat (n) push_byte(8'($urandom_range(0, 255)));
    byte_tally -= n;
  endtask

  // drive the input side
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      s_tuser  <= 1'b0;
    end else if (!s_tvalid || s_fire) begin
      if (in_pause > 0) begin
        s_tvalid <= 1'b0;
        in_pause <= in_pause - 1;
      end else if (raw_q.size() > 0) begin
        nxt = raw_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= nxt.data;
        s_tuser  <= nxt.first;
        in_pause <= pick_pause();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // stall the output side
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (out_pause > 0) begin
      m_tready  <= 1'b0;
      out_pause <= out_pause - 1;
    end else begin
      m_tready  <= 1'b1;
      out_pause <= pick_pause();
    end
  end

  // check results, then predict from the item taken at this edge
  always @(posedge clk) begin
    if (rst) begin
      s_fire      <= 1'b0;
      idle_cycles <= 0;
    end else begin
      s_fire <= (s_tvalid && s_tready) === 1'b1;
      if ((m_tvalid && m_tready) === 1'b1) begin
        if (decoded_q.size() == 0) begin
          errors++;
          if (errors <= 30)
            $display("%0t: unexpected item: actual data=%h last=%b", $time, m_tdata, m_tlast);
        end else begin
          got = decoded_q.pop_front();
          if (got.last) ends_seen++;
          else payload_seen++;
          if (m_tdata !== got.data || m_tlast !== got.last) begin
            errors++;
            if (errors <= 30)
              $display("%0t: expected data=%h last=%b, actual data=%h last=%b",
                       $time, got.data, got.last, m_tdata, m_tlast);
          end
        end
      end
      if ((s_tvalid && s_tready) === 1'b1) decode_byte(s_tdata, s_tuser);
      if ((s_tvalid && s_tready) === 1'b1 || (m_tvalid && m_tready) === 1'b1)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if ($urandom_range(0, 199) == 0) calm <= !calm;
    end
  end

  initial begin
    // sign, extension, NUL and 0xFF in payload, lone 0x ending, ignored byte after the end
    begin_body();
    push_str("+2;x\n");
    push_byte(8'hFF);
    push_byte(CH_NUL);
    push_str("\r\n0x\nZ");
    // negative size
    begin_body();
    push_str("-1\n");
    // sign with no digits
    begin_body();
    push_str("-z");
    // NUL while skipping the size line
    begin_body();
    push_byte("1");
    push_byte(";");
    push_byte(CH_NUL);
    // white space, upper-case 0X, number ended by NUL
    begin_body();
    push_byte(CH_TAB);
    push_str("0X1a");
    push_byte(CH_NUL);

    while (byte_tally < 900) add_random_body();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!(raw_q.size() == 0 && !s_tvalid && decoded_q.size() == 0) &&
           idle_cycles < WATCHDOG_CYCLES)
      @(posedge clk);
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: watchdog expired, %0d results still awaited", $time, decoded_q.size());
      $display("Mismatches found");
    end else begin
      repeat (20) @(posedge clk);
      if (decoded_q.size() != 0) begin
        errors++;
        $display("%0t: %0d expected results never arrived", $time, decoded_q.size());
      end
      $display("Sent %0d bodies, %0d counted input items.", bodies, byte_tally);
      $display("Checked %0d payload bytes and %0d end markers.", payload_seen, ends_seen);
      if (errors == 0) begin
        $display("No mismatches found");
      end else begin
        $display("Mismatches found");
      end
    end
    $finish;
  end

endmodule
